// File: rtl/core/dacq_pkg.sv
// dacq_pkg: shared types, constants and mapping functions of the dithered
// alpha color cube quantizer. Used by dacq_locate, dacq_map and the top level.
// No dependencies.
`default_nettype none

package dacq_pkg;

   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int IMAGE_WIDTH_W = 13;
   localparam int CSR_INDEX_W = 2;
   localparam logic [IMAGE_WIDTH_W-1:0] IMAGE_WIDTH_RESET = 13'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH = 2'd0,
      CSR_TRANSPARENT_BACKGROUND = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       frame_last;
   } dacq_req_type;

   typedef struct packed {
      logic [7:0] palette_index;
      logic       pixel_transparent;
      logic       frame_end;
      logic       any_transparent;
   } dacq_rsp_type;

   // position of a pixel inside the 8x8 dither cell
   typedef struct packed {
      logic [2:0] row;
      logic [2:0] col;
   } dacq_pos_type;

   localparam logic [5:0] BAYER_RANK [64] = '{
      6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
      6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
      6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
      6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
      6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
      6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
      6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
      6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
   };

   // rank * 255 / 64, rounded down
   function automatic logic [7:0] bayer_threshold(input dacq_pos_type pos);
      logic [13:0] prod;
      prod = 14'(BAYER_RANK[{pos.row, pos.col}]) * 14'd255;
      return prod[13:6];
   endfunction

   // c * 5 / 255 rounded down: one step per multiple of 51
   function automatic logic [2:0] level6(input logic [7:0] c);
      return 3'(c >= 8'd51) + 3'(c >= 8'd102) + 3'(c >= 8'd153)
           + 3'(c >= 8'd204) + 3'(c == 8'd255);
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/dacq_locate.sv
// dacq_locate: column counter and row phase of the pixel stream, giving the
// dither cell position of each accepted request. Depends on dacq_pkg.
`default_nettype none

module dacq_locate #(
   parameter int MAX_WIDTH = dacq_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 accept,
   input  wire logic                                 frame_last,
   input  wire logic [dacq_pkg::IMAGE_WIDTH_W-1:0]   image_width,
   output dacq_pkg::dacq_pos_type                    pos
);

   localparam int CNT_W = $clog2(MAX_WIDTH);
   localparam int CMP_W = (CNT_W + 1 > dacq_pkg::IMAGE_WIDTH_W) ?
                          CNT_W + 1 : dacq_pkg::IMAGE_WIDTH_W;

   logic [CNT_W-1:0] col_ff, col_in;
   logic [2:0]       row_ff, row_in;
   logic [CMP_W-1:0] width_ext, width_eff, col_next;

   always_comb begin
      width_ext = CMP_W'(image_width);
      if (width_ext == '0) begin
         width_eff = CMP_W'(1);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      col_next = CMP_W'(col_ff) + CMP_W'(1);

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (frame_last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next >= width_eff) begin
            col_in = '0;
            row_in = row_ff + 3'd1;
         end else begin
            col_in = col_next[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign pos.row = row_ff;
   assign pos.col = col_ff[2:0];

endmodule

`default_nettype wire

// File: rtl/core/dacq_map.sv
// dacq_map: dithered alpha test and 6x6x6 color cube index of one pixel.
// Pure combinational. Depends on dacq_pkg.
`default_nettype none

module dacq_map (
   input  wire dacq_pkg::dacq_req_type  pixel,
   input  wire dacq_pkg::dacq_pos_type  pos,
   input  wire logic                    transparent_mode,
   output logic [7:0]                   palette_index,
   output logic                         transparent
);

   logic [2:0] r_lvl, g_lvl, b_lvl;
   logic [7:0] cube_index;

   always_comb begin
      r_lvl = dacq_pkg::level6(pixel.red);
      g_lvl = dacq_pkg::level6(pixel.green);
      b_lvl = dacq_pkg::level6(pixel.blue);
      cube_index = 8'd1 + 8'(r_lvl) * 8'd36 + 8'(g_lvl) * 8'd6 + 8'(b_lvl);
      transparent = transparent_mode &&
                    (pixel.alpha <= dacq_pkg::bayer_threshold(pos));
      palette_index = transparent ? 8'd0 : cube_index;
   end

endmodule

`default_nettype wire

// File: rtl/core/dithered_alpha_color_cube_quantizer.sv
// Dithered alpha color cube quantizer, top level.
// Takes RGBA pixels in raster order on the req_ channel and returns one
// palette index per pixel on the rsp_ channel; csr_ writes the image width
// (index 0) and the transparent background enable (index 1).
// A request is taken when req_valid is high and req_stall low; a result is
// taken when rsp_valid is high and rsp_stall low. csr_ready is always high.
// A request passes two registers on its way to the result: an input register
// holds the pixel and its dither cell position, then the alpha test and cube
// mapping feed the result register. One pixel per clock is sustained while
// rsp_stall is low; the rate is set by that two-register pipeline.
// While rsp_stall is high the result holds, the input register still takes
// one more request, and req_stall rises only when both registers are full.
// The transparent-seen flag is tracked where results are loaded, in order.
// Synchronous reset empties both registers, clears the column counter, row
// phase and flag, and sets width 1 with transparent background off.
// Dependencies: dacq_pkg, dacq_locate, dacq_map.
`default_nettype none

module dithered_alpha_color_cube_quantizer #(
   parameter int MAX_WIDTH = dacq_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire dacq_pkg::dacq_req_type              req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output dacq_pkg::dacq_rsp_type                   rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [dacq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [dacq_pkg::IMAGE_WIDTH_W-1:0]  csr_wdata
);

   logic [dacq_pkg::IMAGE_WIDTH_W-1:0] width_ff, width_in;
   logic                               mode_ff, mode_in;

   logic                    s1_valid_ff, s1_valid_in;
   dacq_pkg::dacq_req_type  s1_pix_ff, s1_pix_in;
   dacq_pkg::dacq_pos_type  s1_pos_ff, s1_pos_in;
   dacq_pkg::dacq_pos_type  cur_pos;

   logic                    rsp_valid_ff, rsp_valid_in;
   dacq_pkg::dacq_rsp_type  rsp_data_ff, rsp_data_in;
   logic                    seen_ff, seen_in;

   logic       advance, req_accept, load_out, csr_write;
   logic [7:0] map_index;
   logic       map_transparent, any_now;

   // configuration
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      width_in = width_ff;
      mode_in  = mode_ff;
      if (csr_write) begin
         unique case (csr_index)
            dacq_pkg::CSR_IMAGE_WIDTH:            width_in = csr_wdata;
            dacq_pkg::CSR_TRANSPARENT_BACKGROUND: mode_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pipeline control
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign load_out   = s1_valid_ff && advance;

   dacq_locate #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_locate (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .frame_last  (req_data.frame_last),
      .image_width (width_ff),
      .pos         (cur_pos)
   );

   dacq_map u_map (
      .pixel            (s1_pix_ff),
      .pos              (s1_pos_ff),
      .transparent_mode (mode_ff),
      .palette_index    (map_index),
      .transparent      (map_transparent)
   );

   always_comb begin
      s1_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      s1_pix_in   = req_accept ? req_data : s1_pix_ff;
      s1_pos_in   = req_accept ? cur_pos  : s1_pos_ff;

      any_now = seen_ff || map_transparent;
      rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      seen_in      = seen_ff;
      if (load_out) begin
         rsp_data_in.palette_index     = map_index;
         rsp_data_in.pixel_transparent = map_transparent;
         rsp_data_in.frame_end         = s1_pix_ff.frame_last;
         rsp_data_in.any_transparent   = any_now;
         // frame end clears the flag for the next frame
         seen_in = s1_pix_ff.frame_last ? 1'b0 : any_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= dacq_pkg::IMAGE_WIDTH_RESET;
         mode_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seen_ff      <= 1'b0;
      end else begin
         width_ff     <= width_in;
         mode_ff      <= mode_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         seen_ff      <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pix_ff   <= s1_pix_in;
      s1_pos_ff   <= s1_pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // assertions
   a_index_zero_iff_transparent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pixel_transparent == (rsp_data.palette_index == 8'd0)))
      else $error("palette index zero does not match transparency");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.palette_index <= 8'd216))
      else $error("palette index beyond the color cube");

   a_transparent_sets_any: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.pixel_transparent) |-> (rsp_data.any_transparent && mode_ff))
      else $error("transparent pixel without mode or without frame flag");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled while the pipeline has room");

endmodule

`default_nettype wire
